/* sv/mkds_pkg.sv */
// ---------------------------------------------------------------------------
// mkds_pkg: shared types and constants for the keypad debounce scanner
// Matrix geometry, field widths, phase encoding and the key detector.
// ---------------------------------------------------------------------------
package mkds_pkg;

  // Matrix geometry; the snapshot carries at most MATRIX_W keys
  localparam int ROWS     = 4;
  localparam int COLS     = 4;
  localparam int MATRIX_W = 16;
  localparam int NKEYS    = (ROWS * COLS > MATRIX_W) ? MATRIX_W : ROWS * COLS;
  localparam int KEY_W    = 4;
  localparam int CNT_W    = 8;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

  // Scanner phase, one-hot
  typedef enum logic [2:0] {
    PH_SCAN     = 3'b001,
    PH_DEBOUNCE = 3'b010,
    PH_HOLD     = 3'b100
  } phase_e;

  // One result beat
  typedef struct packed {
    logic             key_released;
    logic [KEY_W-1:0] released_key;
  } result_t;

  // Detector output
  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] idx;
  } detect_t;

  // Lowest pressed key in row-major order; keys beyond the matrix are ignored
  function automatic detect_t detect_key(input logic [MATRIX_W-1:0] matrix);
    detect_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int k = NKEYS - 1; k >= 0; k--) begin
      if (matrix[k]) begin
        res.found = 1'b1;
        res.idx   = KEY_W'(k);
      end
    end
    return res;
  endfunction

endpackage

/* sv/mkds_core.sv */
// ---------------------------------------------------------------------------
// mkds_core: scan / debounce / hold state and per-tick step logic
// Holds the phase, held key, debounce counter and the debounce_ticks
// register; computes one result per snapshot and updates state on step_en.
// ---------------------------------------------------------------------------
module mkds_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mkds_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           step_en_i,
  input  logic [mkds_pkg::MATRIX_W-1:0]  key_matrix_i,
  output mkds_pkg::result_t              result_o
);
  import mkds_pkg::*;

  phase_e            phase_q, phase_d;
  logic [KEY_W-1:0]  held_key_q, held_key_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ticks_q;
  detect_t           det;

  assign det = detect_key(key_matrix_i);

  // Compute next state and the result for this snapshot
  always_comb begin
    phase_d    = phase_q;
    held_key_d = held_key_q;
    count_d    = count_q;
    result_o   = '0;
    case (phase_q)
      PH_SCAN: begin
        if (det.found) begin
          held_key_d = det.idx;
          count_d    = '0;
          phase_d    = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (count_q >= ticks_q) begin
          if (det.found && det.idx == held_key_q) begin
            phase_d = PH_HOLD;
          end else begin
            phase_d = PH_SCAN;
          end
        end
        // saturate instead of wrapping
        if (count_q != CNT_MAX) begin
          count_d = count_q + CNT_W'(1);
        end
      end
      PH_HOLD: begin
        if (!det.found || det.idx != held_key_q) begin
          if (!det.found) begin
            result_o.key_released = 1'b1;
            result_o.released_key = held_key_q;
          end
          phase_d = PH_SCAN;
        end
      end
      default: begin
        phase_d = PH_SCAN;
      end
    endcase
  end

  // Advance state once per processed snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      held_key_q <= '0;
      count_q    <= '0;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      held_key_q <= held_key_d;
      count_q    <= count_d;
    end
  end

  // Debounce length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_data_i;
    end
  end

endmodule

/* sv/matrix_keypad_debounce_scanner.sv */
// ---------------------------------------------------------------------------
// matrix_keypad_debounce_scanner: 4x4 keypad scanner with debounce
// Takes one key matrix snapshot per beat and returns one result beat.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o | key_matrix_i[15:0]
//   out     | output    | out_valid_o/ out_stall_i| key_released_o, released_key_o
//   cfg     | input     | cfg_valid_i/ cfg_ready_o| cfg_data_i[7:0] (debounce)
//
// An input beat passes through an input register, then the step logic into
// the result register. One beat per cycle is sustained while the output is
// not stalled; the step logic is a 16-bit priority encoder and an 8-bit compare.
// Reset clears the phase to scanning and sets debounce_ticks to 4.
// A stall on a valid output holds the result register; it holds the input
// register and raises in_stall_o only when the input register is also full.
// ---------------------------------------------------------------------------
module matrix_keypad_debounce_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mkds_pkg::MATRIX_W-1:0]  key_matrix_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           key_released_o,
  output logic [mkds_pkg::KEY_W-1:0]     released_key_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mkds_pkg::CNT_W-1:0]     cfg_data_i
);
  import mkds_pkg::*;

  logic                in_vld_q;
  logic [MATRIX_W-1:0] matrix_q;
  logic                out_vld_q;
  result_t             res_q;
  result_t             step_res;
  logic                out_free;
  logic                step_en;
  logic                in_take;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign step_en     = in_vld_q && out_free;
  assign in_stall_o  = in_vld_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;

  mkds_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .step_en_i    (step_en),
    .key_matrix_i (matrix_q),
    .result_o     (step_res)
  );

  // Input register: take a beat whenever the slot is empty or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      matrix_q <= key_matrix_i;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign key_released_o = res_q.key_released;
  assign released_key_o = res_q.released_key;

endmodule

/* sv/mkds_checker.sv */
// ---------------------------------------------------------------------------
// mkds_checker: port-level checks for the keypad debounce scanner
// Watches the top-level ports and flags handshake or sequencing slips.
// ---------------------------------------------------------------------------
module mkds_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           key_released_o,
  input logic [mkds_pkg::KEY_W-1:0]     released_key_o
);
  import mkds_pkg::*;

  // No result beat is shown while reset is active
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // Input stalls only when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // A release beat is always followed by a non-release beat
  a_no_double_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && key_released_o)
      |=> !(out_valid_o && key_released_o))
    else $error("two release beats in a row");

  // Stalled result holds
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
      |=> (out_valid_o && $stable(key_released_o) && $stable(released_key_o)))
    else $error("stalled result changed");

  // Key index is zero unless a release is reported
  a_idle_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !key_released_o) |-> (released_key_o == '0))
    else $error("released_key nonzero without release");

endmodule

bind matrix_keypad_debounce_scanner mkds_checker u_mkds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .key_released_o (key_released_o),
  .released_key_o (released_key_o)
);
